@@ design/smi_pkg.sv @@
// Shared definitions for the stack machine interpreter core.
// Holds widths, instruction kinds, controller states and the command and
// status structs that join the controller to the datapath. No dependencies.
package smi_pkg;

  localparam int unsigned DATA_W          = 31;
  localparam int unsigned LIMIT_W         = 30;
  localparam int unsigned KIND_W          = 4;
  localparam int unsigned PROD_W          = 2 * DATA_W;
  localparam int unsigned DEF_STACK_DEPTH = 1024;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1000000000);

  typedef enum logic [KIND_W-1:0] {
    K_START = 4'd0,
    K_PUSH  = 4'd1,
    K_POP   = 4'd2,
    K_NEG   = 4'd3,
    K_DUP   = 4'd4,
    K_SWAP  = 4'd5,
    K_ADD   = 4'd6,
    K_SUB   = 4'd7,
    K_MUL   = 4'd8,
    K_DIV   = 4'd9,
    K_MOD   = 4'd10,
    K_END   = 4'd11
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_NEXT,
    ST_UNARY,
    ST_BIN,
    ST_SWAP2,
    ST_DIV,
    ST_CHECK,
    ST_END
  } state_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC,
    CNT_ONE
  } cnt_op_t;

  typedef enum logic [1:0] {
    RD_TOP,
    RD_NEXT,
    RD_BOTTOM
  } rd_sel_t;

  typedef enum logic [1:0] {
    WA_BOTTOM,
    WA_PUSH,
    WA_TOP,
    WA_NEXT
  } wa_sel_t;

  typedef enum logic [2:0] {
    WD_IN,
    WD_RD,
    WD_NEG,
    WD_Y,
    WD_RES
  } wd_sel_t;

  typedef enum logic [2:0] {
    RES_ADD,
    RES_SUB,
    RES_MUL,
    RES_QUO,
    RES_REM
  } res_src_t;

  typedef struct packed {
    logic     err_clr;
    logic     err_set;
    cnt_op_t  cnt_op;
    logic     rd_en;
    rd_sel_t  rd_sel;
    logic     cap_y;
    logic     wr_en;
    wa_sel_t  wa_sel;
    wd_sel_t  wd_sel;
    logic     res_ld;
    res_src_t res_src;
    logic     div_start;
    logic     out_ld;
  } ctrl_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic count_lt2;
    logic count_full;
    logic err;
    logic y_zero;
    logic div_done;
    logic ovf;
  } dp_sts_t;

endpackage

@@ design/smi_div.sv @@
// Iterative restoring divider on unsigned magnitudes, one quotient bit per cycle.
// Depends on smi_pkg for the data width.
module smi_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [smi_pkg::DATA_W-1:0] dividend,
  input  logic [smi_pkg::DATA_W-1:0] divisor,
  output logic                       done,
  output logic [smi_pkg::DATA_W-1:0] quotient,
  output logic [smi_pkg::DATA_W-1:0] remainder
);
  import smi_pkg::*;

  localparam int unsigned CW = $clog2(DATA_W);

  logic [DATA_W-1:0] quo_r, quo_nxt;
  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DATA_W-1:0] dvs_r;
  logic [CW-1:0]     cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DATA_W:0]   rem_sh;
  logic [DATA_W:0]   diff;

  // Shift in the next dividend bit and subtract the divisor when it fits.
  always_comb begin
    rem_sh = {rem_r, quo_r[DATA_W-1]};
    diff   = rem_sh - {1'b0, dvs_r};
    if (rem_sh >= {1'b0, dvs_r}) begin
      rem_nxt = diff[DATA_W-1:0];
      quo_nxt = {quo_r[DATA_W-2:0], 1'b1};
    end else begin
      rem_nxt = rem_sh[DATA_W-1:0];
      quo_nxt = {quo_r[DATA_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
      cnt_r <= CW'(DATA_W - 1);
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
      cnt_r <= cnt_r - CW'(1);
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

@@ design/smi_dpath.sv @@
// Datapath: stack memory, entry count, error flag, limit register, arithmetic
// and output registers. Depends on smi_pkg and instantiates smi_div.
module smi_dpath #(
  parameter int unsigned STACK_DEPTH = smi_pkg::DEF_STACK_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic signed [smi_pkg::DATA_W-1:0]  in_operand,
  input  logic                               cfg_wr_en,
  input  logic        [smi_pkg::LIMIT_W-1:0] cfg_overflow_limit,
  input  smi_pkg::ctrl_cmd_t                 cmd,
  output smi_pkg::dp_sts_t                   sts,
  output logic signed [smi_pkg::DATA_W-1:0]  out_value,
  output logic                               out_error
);
  import smi_pkg::*;

  localparam int unsigned AW    = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);

  logic [DATA_W-1:0]  mem [STACK_DEPTH];
  logic [LIMIT_W-1:0] limit_r;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               err_r;
  logic [DATA_W-1:0]  rd_data_r;
  logic [DATA_W-1:0]  y_r;
  logic [PROD_W-1:0]  res_mag_r, res_mag_nxt;
  logic               res_neg_r, res_neg_nxt;
  logic [DATA_W-1:0]  out_value_r;
  logic               out_error_r;

  logic [AW-1:0]      addr_bottom, addr_push, addr_top, addr_next;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic [DATA_W-1:0]  wr_data;
  logic [DATA_W-1:0]  res_val;
  logic               out_err_nxt;

  logic signed [DATA_W-1:0] x_s, y_s;
  logic signed [DATA_W:0]   sum, dif;
  logic signed [PROD_W-1:0] prod;
  logic [DATA_W:0]          sum_mag, dif_mag;
  logic [PROD_W-1:0]        prod_mag;
  logic [DATA_W-1:0]        x_mag, y_mag;
  logic                     div_done;
  logic [DATA_W-1:0]        quo_mag, rem_mag;

  // Stack addresses relative to the current entry count.
  assign addr_bottom = '0;
  assign addr_push   = count_r[AW-1:0];
  assign addr_top    = AW'(count_r - CNT_W'(1));
  assign addr_next   = AW'(count_r - CNT_W'(2));

  always_comb begin
    case (cmd.rd_sel)
      RD_TOP:  rd_addr = addr_top;
      RD_NEXT: rd_addr = addr_next;
      default: rd_addr = addr_bottom;
    endcase
    case (cmd.wa_sel)
      WA_BOTTOM: wr_addr = addr_bottom;
      WA_PUSH:   wr_addr = addr_push;
      WA_TOP:    wr_addr = addr_top;
      default:   wr_addr = addr_next;
    endcase
  end

  // A stored result has already passed the limit check, so its magnitude fits in 30 bits.
  assign res_val = res_neg_r ? -res_mag_r[DATA_W-1:0] : res_mag_r[DATA_W-1:0];

  always_comb begin
    case (cmd.wd_sel)
      WD_IN:   wr_data = in_operand;
      WD_RD:   wr_data = rd_data_r;
      WD_NEG:  wr_data = -rd_data_r;
      WD_Y:    wr_data = y_r;
      default: wr_data = res_val;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Operand x is the read register, operand y was captured one read earlier.
  assign x_s   = rd_data_r;
  assign y_s   = y_r;
  assign sum   = (DATA_W + 1)'(x_s) + (DATA_W + 1)'(y_s);
  assign dif   = (DATA_W + 1)'(x_s) - (DATA_W + 1)'(y_s);
  assign prod  = x_s * y_s;
  assign sum_mag  = sum[DATA_W] ? -sum : sum;
  assign dif_mag  = dif[DATA_W] ? -dif : dif;
  assign prod_mag = prod[PROD_W-1] ? -prod : prod;
  assign x_mag = x_s[DATA_W-1] ? -rd_data_r : rd_data_r;
  assign y_mag = y_s[DATA_W-1] ? -y_r : y_r;

  smi_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (x_mag),
    .divisor   (y_mag),
    .done      (div_done),
    .quotient  (quo_mag),
    .remainder (rem_mag)
  );

  always_comb begin
    case (cmd.res_src)
      RES_ADD: begin
        res_mag_nxt = PROD_W'(sum_mag);
        res_neg_nxt = sum[DATA_W];
      end
      RES_SUB: begin
        res_mag_nxt = PROD_W'(dif_mag);
        res_neg_nxt = dif[DATA_W];
      end
      RES_MUL: begin
        res_mag_nxt = prod_mag;
        res_neg_nxt = prod[PROD_W-1];
      end
      RES_QUO: begin
        res_mag_nxt = PROD_W'(quo_mag);
        res_neg_nxt = x_s[DATA_W-1] ^ y_s[DATA_W-1];
      end
      default: begin
        res_mag_nxt = PROD_W'(rem_mag);
        res_neg_nxt = x_s[DATA_W-1];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_y) begin
      y_r <= rd_data_r;
    end
    if (cmd.res_ld) begin
      res_mag_r <= res_mag_nxt;
      res_neg_r <= res_neg_nxt;
    end
  end

  always_comb begin
    case (cmd.cnt_op)
      CNT_INC: count_nxt = count_r + CNT_W'(1);
      CNT_DEC: count_nxt = count_r - CNT_W'(1);
      CNT_ONE: count_nxt = CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      err_r   <= 1'b0;
      limit_r <= LIMIT_RESET;
    end else begin
      count_r <= count_nxt;
      if (cmd.err_clr) begin
        err_r <= 1'b0;
      end else if (cmd.err_set) begin
        err_r <= 1'b1;
      end
      if (cfg_wr_en) begin
        limit_r <= cfg_overflow_limit;
      end
    end
  end

  assign out_err_nxt = err_r || (count_r != CNT_W'(1));

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_error_r <= out_err_nxt;
      out_value_r <= out_err_nxt ? '0 : rd_data_r;
    end
  end

  assign sts.count_zero = (count_r == '0);
  assign sts.count_lt2  = (count_r < CNT_W'(2));
  assign sts.count_full = (count_r == CNT_W'(STACK_DEPTH));
  assign sts.err        = err_r;
  assign sts.y_zero     = (y_r == '0);
  assign sts.div_done   = div_done;
  assign sts.ovf        = (res_mag_r > PROD_W'(limit_r));

  assign out_value = out_value_r;
  assign out_error = out_error_r;

endmodule

@@ design/smi_ctrl.sv @@
// Controller state machine: decodes each instruction and sequences the datapath.
// Depends on smi_pkg for the kind, state, command and status types.
module smi_ctrl (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic        [smi_pkg::KIND_W-1:0]  in_kind,
  output logic                               out_valid,
  input  logic                               out_stall,
  input  smi_pkg::dp_sts_t                   sts,
  output smi_pkg::ctrl_cmd_t                 cmd
);
  import smi_pkg::*;

  state_t state_r, state_nxt;
  kind_t  kind_r, kind_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      kind_r      <= K_START;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      kind_r      <= kind_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    cmd.err_clr   = 1'b0;
    cmd.err_set   = 1'b0;
    cmd.cnt_op    = CNT_HOLD;
    cmd.rd_en     = 1'b0;
    cmd.rd_sel    = RD_TOP;
    cmd.cap_y     = 1'b0;
    cmd.wr_en     = 1'b0;
    cmd.wa_sel    = WA_PUSH;
    cmd.wd_sel    = WD_IN;
    cmd.res_ld    = 1'b0;
    cmd.res_src   = RES_ADD;
    cmd.div_start = 1'b0;
    cmd.out_ld    = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          kind_nxt = kind_t'(in_kind);
          case (kind_t'(in_kind))
            K_START: begin
              cmd.err_clr = 1'b1;
              cmd.wr_en   = 1'b1;
              cmd.wa_sel  = WA_BOTTOM;
              cmd.wd_sel  = WD_IN;
              cmd.cnt_op  = CNT_ONE;
            end
            K_END: begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_BOTTOM;
              state_nxt  = ST_END;
            end
            K_PUSH: begin
              if (!sts.err) begin
                if (sts.count_full) begin
                  cmd.err_set = 1'b1;
                end else begin
                  cmd.wr_en  = 1'b1;
                  cmd.wa_sel = WA_PUSH;
                  cmd.wd_sel = WD_IN;
                  cmd.cnt_op = CNT_INC;
                end
              end
            end
            K_POP: begin
              if (!sts.err) begin
                if (sts.count_zero) begin
                  cmd.err_set = 1'b1;
                end else begin
                  cmd.cnt_op = CNT_DEC;
                end
              end
            end
            K_NEG, K_DUP: begin
              if (!sts.err) begin
                if (sts.count_zero) begin
                  cmd.err_set = 1'b1;
                end else begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = RD_TOP;
                  state_nxt  = ST_UNARY;
                end
              end
            end
            K_SWAP, K_ADD, K_SUB, K_MUL, K_DIV, K_MOD: begin
              if (!sts.err) begin
                if (sts.count_lt2) begin
                  cmd.err_set = 1'b1;
                end else begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = RD_TOP;
                  state_nxt  = ST_RD_NEXT;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_RD_NEXT: begin
        cmd.cap_y  = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_NEXT;
        state_nxt  = ST_BIN;
      end

      ST_UNARY: begin
        state_nxt = ST_IDLE;
        if (kind_r == K_NEG) begin
          cmd.wr_en  = 1'b1;
          cmd.wa_sel = WA_TOP;
          cmd.wd_sel = WD_NEG;
        end else if (sts.count_full) begin
          cmd.err_set = 1'b1;
        end else begin
          cmd.wr_en  = 1'b1;
          cmd.wa_sel = WA_PUSH;
          cmd.wd_sel = WD_RD;
          cmd.cnt_op = CNT_INC;
        end
      end

      ST_BIN: begin
        case (kind_r)
          K_SWAP: begin
            cmd.wr_en  = 1'b1;
            cmd.wa_sel = WA_TOP;
            cmd.wd_sel = WD_RD;
            state_nxt  = ST_SWAP2;
          end
          K_ADD: begin
            cmd.res_ld  = 1'b1;
            cmd.res_src = RES_ADD;
            state_nxt   = ST_CHECK;
          end
          K_SUB: begin
            cmd.res_ld  = 1'b1;
            cmd.res_src = RES_SUB;
            state_nxt   = ST_CHECK;
          end
          K_MUL: begin
            cmd.res_ld  = 1'b1;
            cmd.res_src = RES_MUL;
            state_nxt   = ST_CHECK;
          end
          K_DIV, K_MOD: begin
            if (sts.y_zero) begin
              cmd.err_set = 1'b1;
              state_nxt   = ST_IDLE;
            end else begin
              cmd.div_start = 1'b1;
              state_nxt     = ST_DIV;
            end
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end

      ST_SWAP2: begin
        cmd.wr_en  = 1'b1;
        cmd.wa_sel = WA_NEXT;
        cmd.wd_sel = WD_Y;
        state_nxt  = ST_IDLE;
      end

      ST_DIV: begin
        if (sts.div_done) begin
          cmd.res_ld  = 1'b1;
          cmd.res_src = (kind_r == K_DIV) ? RES_QUO : RES_REM;
          state_nxt   = ST_CHECK;
        end
      end

      ST_CHECK: begin
        state_nxt = ST_IDLE;
        if (sts.ovf) begin
          cmd.err_set = 1'b1;
        end else begin
          cmd.wr_en  = 1'b1;
          cmd.wa_sel = WA_NEXT;
          cmd.wd_sel = WD_RES;
          cmd.cnt_op = CNT_DEC;
        end
      end

      ST_END: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_ld = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_ld) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

@@ design/stack_machine_interpreter_core.sv @@
// Top level of the stack machine interpreter core.
// Depends on smi_pkg and instantiates smi_ctrl and smi_dpath.
//
// The core runs a stack-machine program, one instruction per input
// transaction (start, push, pop, negate, dup, swap, add, sub, mul, div, mod,
// end); only an end instruction produces an output transaction, carrying the
// single stack entry or an error flag with a zero value. Instructions are
// taken one at a time and in_stall stays high until the current one is done.
// Start, push, pop and unused kinds finish in the idle state; negate and dup
// read the top entry and then write; swap, add, subtract and multiply read
// the top and next entries and then write; an end reads the bottom entry and
// loads the output register, waiting while out_stall holds a result there.
// Divide and modulo wait on the restoring divider, which yields one quotient
// bit per cycle over the 31-bit magnitudes; a zero divisor is caught before
// it starts. Skipped instructions under a latched error, or ones that find
// too few stack entries, finish in the idle state. The stack memory has one
// read port and one write port and delivers one registered read per cycle.
// A finished result sits in the output register while the next instructions
// are accepted; only a following end instruction waits for it to drain. The
// stack memory needs no clearing after reset, so the core is ready in the
// first cycle after rst_n rises. The overflow limit register may be written
// through cfg_wr_en whenever no instruction is in flight.
module stack_machine_interpreter_core #(
  parameter int unsigned STACK_DEPTH = smi_pkg::DEF_STACK_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic        [smi_pkg::KIND_W-1:0]  in_kind,
  input  logic signed [smi_pkg::DATA_W-1:0]  in_operand,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [smi_pkg::DATA_W-1:0]  out_value,
  output logic                               out_error,
  input  logic                               cfg_wr_en,
  input  logic        [smi_pkg::LIMIT_W-1:0] cfg_overflow_limit
);
  import smi_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  // The controller owns the handshakes and the sequencing of each instruction.
  smi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_kind   (in_kind),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the stack, the error flag, the limit and the result.
  smi_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_operand         (in_operand),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_overflow_limit (cfg_overflow_limit),
    .cmd                (cmd),
    .sts                (sts),
    .out_value          (out_value),
    .out_error          (out_error)
  );

endmodule

@@ design/smi_checker.sv @@
// Port-level checker for the stack machine interpreter core, with its bind.
// Depends on smi_pkg for the instruction kind codes.
module smi_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic        [smi_pkg::KIND_W-1:0]  in_kind,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic signed [smi_pkg::DATA_W-1:0]  out_value,
  input logic                               out_error
);
  import smi_pkg::*;

  // A stalled output transaction keeps its valid and payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value) && $stable(out_error))
    else $error("output transaction changed while stalled");

  // An error result always carries a zero value.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_value == '0)
    else $error("error result with nonzero value");

  // An accepted end instruction holds off the input until its result is loaded.
  a_end_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_kind == K_END |=> in_stall)
    else $error("input not stalled after end instruction");

  // A start instruction leaves in_stall low in the cycle after it is accepted.
  a_start_one: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_kind == K_START |=> !in_stall)
    else $error("start instruction took more than one cycle");

  // A new result only appears at the end of an end instruction.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without an end instruction in flight");

endmodule

bind stack_machine_interpreter_core smi_checker u_smi_checker (.*);

@@ test/stack_machine_interpreter_core_tb.sv @@
// Self-checking testbench for stack_machine_interpreter_core.
// Depends on smi_pkg and the core; a calculator model or a typed-in row predicts
// every end-of-program transaction and the monitor checks it field by field.
module stack_machine_interpreter_core_tb;
  import smi_pkg::*;

  localparam int unsigned STACK_DEPTH   = DEF_STACK_DEPTH;
  localparam int          ITEMS_PER_SEG = 80;
  localparam int          SEGMENTS      = 6;
  localparam int          DRAIN_SETTLE  = 50;   // covers a full divide after the last end
  localparam int          LONG_HOLD     = 400;
  localparam int          QUIET_LIMIT   = 4000;
  localparam int          DIR_ROWS      = 43;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 4'd13;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     error;
  } calc_out_t;

  // One row of the directed program: an instruction, how often to repeat it and,
  // for end rows whose outcome is obvious, the result typed in by hand.
  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic signed [DATA_W-1:0] operand;
    int                       reps;
    bit                       typed;
    logic signed [DATA_W-1:0] value;
    bit                       error;
  } dir_row_t;

  logic                        clk;
  logic                        rst_n              = 1'b0;
  logic                        in_valid           = 1'b0;
  logic                        in_stall;
  logic [KIND_W-1:0]           in_kind            = '0;
  logic signed [DATA_W-1:0]    in_operand         = '0;
  logic                        out_valid;
  logic                        out_stall          = 1'b0;
  logic signed [DATA_W-1:0]    out_value;
  logic                        out_error;
  logic                        cfg_wr_en          = 1'b0;
  logic [LIMIT_W-1:0]          cfg_overflow_limit = LIMIT_RESET;

  // Calculator model state.
  logic signed [DATA_W-1:0]    calc_stack [STACK_DEPTH];
  int                          calc_depth = 0;
  bit                          calc_fault = 1'b0;
  logic [LIMIT_W-1:0]          calc_limit = LIMIT_RESET;

  calc_out_t                   due_results [$];
  int                          bad_count    = 0;
  int                          quiet_cycles = 0;
  int                          sent_items   = 0;
  int unsigned                 send_idle_pct  = 10;
  int unsigned                 recv_stall_pct = 54;
  int                          hold_seq  = 0;
  int                          hold_seen = 0;
  int                          hold_left = 0;

  // Hand-typed fields of the transaction currently offered.
  bit                          row_typed = 1'b0;
  logic signed [DATA_W-1:0]    row_value = '0;
  bit                          row_error = 1'b0;

  dir_row_t dir_tab [DIR_ROWS] = '{
    '{K_END,        0,           1,             1'b1, 0,           1'b1},
    '{K_POP,        0,           1,             1'b0, 0,           1'b0},
    '{K_END,        0,           1,             1'b1, 0,           1'b1},
    '{K_START,      1000000000,  1,             1'b0, 0,           1'b0},
    '{K_END,        0,           1,             1'b1, 1000000000,  1'b0},
    '{K_PUSH,       -1000000000, 1,             1'b0, 0,           1'b0},
    '{K_ADD,        0,           1,             1'b0, 0,           1'b0},
    '{K_PUSH,       0,           1,             1'b0, 0,           1'b0},
    '{K_DIV,        0,           1,             1'b0, 0,           1'b0},
    '{K_END,        0,           1,             1'b1, 0,           1'b1},
    '{K_START,      -7,          1,             1'b0, 0,           1'b0},
    '{K_PUSH,       2,           1,             1'b0, 0,           1'b0},
    '{K_MOD,        0,           1,             1'b0, 0,           1'b0},
    '{K_PUSH,       -1073741824, 1,             1'b0, 0,           1'b0},
    '{K_NEG,        0,           1,             1'b0, 0,           1'b0},
    '{K_SWAP,       0,           1,             1'b0, 0,           1'b0},
    '{K_POP,        0,           1,             1'b0, 0,           1'b0},
    '{K_END,        0,           1,             1'b1, -1073741824, 1'b0},
    '{K_DUP,        0,           1,             1'b0, 0,           1'b0},
    '{K_MUL,        0,           1,             1'b0, 0,           1'b0},
    '{KIND_UNUSED,  12345,       1,             1'b0, 0,           1'b0},
    '{K_END,        0,           1,             1'b1, 0,           1'b1},
    '{K_START,      9,           1,             1'b0, 0,           1'b0},
    '{K_DUP,        0,           1,             1'b0, 0,           1'b0},
    '{K_MUL,        0,           1,             1'b0, 0,           1'b0},
    '{K_PUSH,       -2,          1,             1'b0, 0,           1'b0},
    '{K_DIV,        0,           1,             1'b0, 0,           1'b0},
    '{K_END,        0,           1,             1'b0, 0,           1'b0},
    '{K_PUSH,       5,           1,             1'b0, 0,           1'b0},
    '{K_SUB,        0,           1,             1'b0, 0,           1'b0},
    '{K_END,        0,           1,             1'b0, 0,           1'b0},
    '{K_START,      3,           1,             1'b0, 0,           1'b0},
    '{K_PUSH,       0,           1,             1'b0, 0,           1'b0},
    '{K_MOD,        0,           1,             1'b0, 0,           1'b0},
    '{K_END,        0,           1,             1'b1, 0,           1'b1},
    '{K_START,      6,           1,             1'b0, 0,           1'b0},
    '{K_SWAP,       0,           1,             1'b0, 0,           1'b0},
    '{K_END,        0,           1,             1'b1, 0,           1'b1},
    '{K_START,      1,           1,             1'b0, 0,           1'b0},
    '{K_PUSH,       -1000000000, STACK_DEPTH-2, 1'b0, 0,           1'b0},
    '{K_DUP,        0,           1,             1'b0, 0,           1'b0},
    '{K_PUSH,       7,           1,             1'b0, 0,           1'b0},
    '{K_END,        0,           1,             1'b1, 0,           1'b1}
  };

  stack_machine_interpreter_core #(
    .STACK_DEPTH(STACK_DEPTH)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_kind            (in_kind),
    .in_operand         (in_operand),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_value          (out_value),
    .out_error          (out_error),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_overflow_limit (cfg_overflow_limit)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Calculator model
  // ---------------------------------------------------------------------------
  task automatic calc_push(input logic signed [DATA_W-1:0] v);
    if (calc_depth >= STACK_DEPTH) begin
      calc_fault = 1'b1;
    end else begin
      calc_stack[calc_depth] = v;
      calc_depth++;
    end
  endtask

  task automatic calc_step(input logic [KIND_W-1:0] k, input logic signed [DATA_W-1:0] opnd,
                           output bit emits, output calc_out_t res);
    longint x, y, r, mag;
    emits = 1'b0;
    res   = '0;
    if (k == K_START) begin
      calc_depth = 0;
      calc_fault = 1'b0;
      calc_push(opnd);
    end else if (k == K_END) begin
      emits = 1'b1;
      if (!calc_fault && calc_depth == 1) res = '{calc_stack[0], 1'b0};
      else res = '{'0, 1'b1};
    end else if (k < K_END && !calc_fault) begin
      case (k)
        K_PUSH: calc_push(opnd);
        K_POP, K_NEG, K_DUP: begin
          if (calc_depth == 0) calc_fault = 1'b1;
          else if (k == K_POP) calc_depth--;
          else if (k == K_NEG) calc_stack[calc_depth-1] = -calc_stack[calc_depth-1];
          else calc_push(calc_stack[calc_depth-1]);
        end
        default: begin
          if (calc_depth < 2) begin
            calc_fault = 1'b1;
          end else begin
            y = calc_stack[calc_depth-1];
            x = calc_stack[calc_depth-2];
            if (k == K_SWAP) begin
              calc_stack[calc_depth-1] = x[DATA_W-1:0];
              calc_stack[calc_depth-2] = y[DATA_W-1:0];
            end else if ((k == K_DIV || k == K_MOD) && y == 0) begin
              calc_fault = 1'b1;
            end else begin
              case (k)
                K_ADD:   r = x + y;
                K_SUB:   r = x - y;
                K_MUL:   r = x * y;
                K_DIV:   r = x / y;
                default: r = x % y;
              endcase
              mag = (r < 0) ? -r : r;
              if (mag > longint'(calc_limit)) begin
                calc_fault = 1'b1;
              end else begin
                calc_depth -= 2;
                calc_push(r[DATA_W-1:0]);
              end
            end
          end
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: outputs are checked before the same edge's input is predicted.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    calc_out_t due, fresh;
    bit        emits;
    if (rst_n) begin
      quiet_cycles++;
      if (out_valid && !out_stall) begin
        quiet_cycles = 0;
        if (due_results.size() == 0) begin
          bad_count++;
          if (bad_count <= 10)
            $display("unexpected result transaction: value %0d error %0b", out_value, out_error);
        end else begin
          due = due_results.pop_front();
          if (out_value !== due.value || out_error !== due.error) begin
            bad_count++;
            if (bad_count <= 10)
              $display("result mismatch: expected value %0d error %0b, got value %0d error %0b",
                       due.value, due.error, out_value, out_error);
          end
        end
      end
      if (in_valid && !in_stall) begin
        quiet_cycles = 0;
        calc_step(in_kind, in_operand, emits, fresh);
        if (emits) begin
          if (row_typed) fresh = '{row_value, row_error};
          due_results = {due_results, fresh};
        end
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when the stimulus asks for one.
  always @(negedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall = 1'b1;
    end else begin
      out_stall = ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
    $display("FAIL stack_machine_interpreter_core");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers; all of them start and end at a falling edge.
  // ---------------------------------------------------------------------------
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return '0;
      1:       return DATA_W'(1000000000);
      2:       return DATA_W'(-1000000000);
      3, 4:    return DATA_W'(int'($urandom_range(40000)) - 20000);
      5, 6, 7: return DATA_W'(int'($urandom_range(40)) - 20);
      default: return DATA_W'(int'($urandom_range(2000000000)) - 1000000000);
    endcase
  endfunction

  task automatic send_item(input logic [KIND_W-1:0] k, input logic signed [DATA_W-1:0] v,
                           input bit typed = 1'b0,
                           input logic signed [DATA_W-1:0] typed_value = '0,
                           input bit typed_error = 1'b0);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    in_kind    = k;
    in_operand = v;
    row_typed  = typed;
    row_value  = typed_value;
    row_error  = typed_error;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    if (k <= K_END) sent_items++;
  endtask

  // Pause the sender until every result is back, then let any trailing
  // instruction that produces no result finish as well.
  task automatic wait_drained(input int settle);
    in_valid = 1'b0;
    while (due_results.size() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic set_limit(input logic [LIMIT_W-1:0] v);
    cfg_wr_en          = 1'b1;
    cfg_overflow_limit = v;
    calc_limit         = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int                 seg, depth, n, r;
    logic [LIMIT_W-1:0] limit_v;
    logic [KIND_W-1:0]  op;

    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // Directed program at the reset limit, including a full-stack fill.
    foreach (dir_tab[i])
      repeat (dir_tab[i].reps)
        send_item(dir_tab[i].kind, dir_tab[i].operand, dir_tab[i].typed,
                  dir_tab[i].value, dir_tab[i].error);

    sent_items = 0;
    for (seg = 0; seg < SEGMENTS; seg++) begin
      wait_drained(DRAIN_SETTLE);
      case (seg)
        0:       limit_v = LIMIT_RESET;
        1:       limit_v = '0;
        2:       limit_v = LIMIT_W'(1000000);
        3:       limit_v = LIMIT_W'(1);
        4:       limit_v = LIMIT_W'($urandom_range(1000000000));
        default: limit_v = LIMIT_W'(1000000000);
      endcase
      set_limit(limit_v);
      send_idle_pct  = (seg < 2) ? 10 : (seg < 4) ? 54 : 0;
      recv_stall_pct = (seg < 2) ? 54 : (seg < 4) ? 10 : 0;
      // Back-pressure the output for a long stretch so that ends pile up.
      if (seg == 4) hold_seq++;

      while (sent_items < (seg + 1) * ITEMS_PER_SEG) begin
        if ($urandom_range(9) == 0) begin
          // Noise: any kind, including unused ones, with no program structure.
          n = $urandom_range(6, 1);
          repeat (n) send_item(KIND_W'($urandom_range(15)), pick_value());
        end else begin
          // Mostly well-formed program: start, a body that tracks stack depth,
          // an optional collapse down to one entry, then end.
          send_item(K_START, pick_value());
          depth = 1;
          n = $urandom_range(12);
          repeat (n) begin
            r = $urandom_range(99);
            if ((depth < 2 && r < 60) || r < 20) begin
              send_item(K_PUSH, pick_value());
              depth++;
            end else if (r < 30) begin
              send_item(K_DUP, pick_value());
              depth++;
            end else if (r < 40) begin
              send_item(K_NEG, pick_value());
            end else if (r < 48) begin
              send_item(K_SWAP, pick_value());
            end else begin
              op = (r < 55) ? K_POP : KIND_W'(K_ADD + $urandom_range(4));
              send_item(op, pick_value());
              depth = (depth > 0) ? depth - 1 : 0;
            end
          end
          while (depth > 1 && $urandom_range(9) != 0) begin
            op = ($urandom_range(5) == 0) ? K_POP : KIND_W'(K_ADD + $urandom_range(4));
            send_item(op, pick_value());
            depth--;
          end
          send_item(K_END, pick_value());
        end
      end
    end

    wait_drained(DRAIN_SETTLE);
    if (bad_count == 0 && due_results.size() == 0) begin
      $display("PASS stack_machine_interpreter_core");
    end else begin
      $display("FAIL stack_machine_interpreter_core");
    end
    $finish;
  end

endmodule

@@ stack_machine_interpreter_core.f @@
design/smi_pkg.sv
design/smi_div.sv
design/smi_dpath.sv
design/smi_ctrl.sv
design/stack_machine_interpreter_core.sv
design/smi_checker.sv
test/stack_machine_interpreter_core_tb.sv
